// ===== rtl/scd_pkg.sv =====
package scd_pkg;

   // Defaults of the top-level parameters
   localparam int SLOTS_DEF        = 4;
   localparam int SECTOR_BYTES_DEF = 4096;
   localparam int BLOCK_BYTES_DEF  = 512;

   // Fixed field widths
   localparam int OP_W    = 3;
   localparam int BLK_W   = 32;
   localparam int OFS_W   = 9;
   localparam int KIND_W  = 3;
   localparam int SLOT_W  = 2;
   localparam int TAG_W   = 12;
   localparam int BYTE_W  = 12;
   localparam int DISK_W  = 16;

   // Reset block count: an 8 MiB flash in 512-byte blocks
   localparam logic [DISK_W-1:0] DISK_BLOCKS_RST = DISK_W'(8 * 1024 * 1024 / 512);

   // Operation codes
   localparam logic [OP_W-1:0] OP_READ       = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE      = 3'd1;
   localparam logic [OP_W-1:0] OP_START_STOP = 3'd2;
   localparam logic [OP_W-1:0] OP_SERVICE    = 3'd3;
   localparam logic [OP_W-1:0] OP_FLUSH_ALL  = 3'd4;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_GRANT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WB    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FILL  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ERROR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_VICTIM,
      ST_FILL,
      ST_GRANT,
      ST_FLUSH,
      ST_DONE
   } state_type;

   // Directory write command
   typedef struct packed {
      logic fill;
      logic set_dirty;
      logic clr_dirty;
   } dir_wr_type;

   // Directory read port with tag compare result
   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic             hit;
      logic [TAG_W-1:0] tag;
   } dir_rd_type;

endpackage

// ===== rtl/scd_if.sv =====
interface scd_req_if;
   logic                       valid;
   logic                       ready;
   logic [scd_pkg::OP_W-1:0]   operation;
   logic [scd_pkg::BLK_W-1:0]  block_number;
   logic [scd_pkg::OFS_W-1:0]  block_offset;
   logic                       eject;

   modport source (output valid, output operation, output block_number,
                   output block_offset, output eject, input ready);
   modport sink   (input valid, input operation, input block_number,
                   input block_offset, input eject, output ready);
endinterface

interface scd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [scd_pkg::KIND_W-1:0] kind;
   logic [scd_pkg::SLOT_W-1:0] slot;
   logic [scd_pkg::TAG_W-1:0]  sector_number;
   logic [scd_pkg::BYTE_W-1:0] byte_in_sector;
   logic                       hit;
   logic                       flushed;
   logic                       last;

   modport source (output valid, output kind, output slot, output sector_number,
                   output byte_in_sector, output hit, output flushed, output last,
                   input ready);
   modport sink   (input valid, input kind, input slot, input sector_number,
                   input byte_in_sector, input hit, input flushed, input last,
                   output ready);
endinterface

interface scd_csr_if;
   logic                       valid;
   logic                       ready;
   logic [scd_pkg::DISK_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/write_back_sector_cache_directory_unit.sv =====
// Channel  Dir  Handshake     Carries
// req      in   valid/ready   operation, block_number, block_offset, eject
// rsp      out  valid/ready   kind, slot, sector_number, byte_in_sector, hit, flushed, last
// csr      in   valid/ready   data: disk block count (16 bit)
//
// One sequencer steps a single directory read port and tag comparator over the slots,
// one slot per cycle, save where a flush write-back waits on a stalled rsp. An access
// scans up to a hit or the last slot, on a miss writes back a dirty victim and fills, then
// grants; a flush writes back every dirty slot, then reports done. Unused codes give no
// result. Each result waits in an output register; a stalled rsp holds req and each step
// that loads a result. Synchronous reset empties the directory and flush mark.
module write_back_sector_cache_directory_unit #(
   parameter int SLOTS        = scd_pkg::SLOTS_DEF,
   parameter int SECTOR_BYTES = scd_pkg::SECTOR_BYTES_DEF,
   parameter int BLOCK_BYTES  = scd_pkg::BLOCK_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   scd_req_if.sink    req,
   scd_rsp_if.source  rsp,
   scd_csr_if.sink    csr
);

   // Block count register, taking every transfer; user writes only while idle, unenforced
   logic [scd_pkg::DISK_W-1:0] disk_blocks_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_blocks_ff <= scd_pkg::DISK_BLOCKS_RST;
      end else if (csr.valid && csr.ready) begin
         disk_blocks_ff <= csr.data;
      end
   end

   // Sequencer with the directory and its shared comparator
   scd_seq #(
      .SLOTS        (SLOTS),
      .SECTOR_BYTES (SECTOR_BYTES),
      .BLOCK_BYTES  (BLOCK_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .disk_blocks (disk_blocks_ff),
      .req         (req),
      .rsp         (rsp)
   );

endmodule

// ===== rtl/scd_dir.sv =====
module scd_dir #(
   parameter int SLOTS = scd_pkg::SLOTS_DEF,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [IDX_W-1:0]          rd_idx,
   input  logic [scd_pkg::TAG_W-1:0] look_tag,
   output scd_pkg::dir_rd_type       rd,
   input  scd_pkg::dir_wr_type       wr_cmd,
   input  logic [IDX_W-1:0]          wr_idx,
   input  logic [scd_pkg::TAG_W-1:0] wr_tag
);

   logic [scd_pkg::TAG_W-1:0] tag_ff   [SLOTS];
   logic [SLOTS-1:0]          valid_ff;
   logic [SLOTS-1:0]          dirty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            tag_ff[i] <= '1;
         end
      end else begin
         if (wr_cmd.fill) begin
            tag_ff[wr_idx]   <= wr_tag;
            valid_ff[wr_idx] <= 1'b1;
            dirty_ff[wr_idx] <= 1'b0;
         end else if (wr_cmd.set_dirty) begin
            dirty_ff[wr_idx] <= 1'b1;
         end else if (wr_cmd.clr_dirty) begin
            dirty_ff[wr_idx] <= 1'b0;
         end
      end
   end

   // Single read port plus the shared tag comparator
   always_comb begin
      rd.valid = valid_ff[rd_idx];
      rd.dirty = dirty_ff[rd_idx];
      rd.tag   = tag_ff[rd_idx];
      rd.hit   = valid_ff[rd_idx] && (tag_ff[rd_idx] == look_tag);
   end

endmodule

// ===== rtl/scd_seq.sv =====
module scd_seq #(
   parameter int SLOTS        = scd_pkg::SLOTS_DEF,
   parameter int SECTOR_BYTES = scd_pkg::SECTOR_BYTES_DEF,
   parameter int BLOCK_BYTES  = scd_pkg::BLOCK_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [scd_pkg::DISK_W-1:0] disk_blocks,
   scd_req_if.sink                    req,
   scd_rsp_if.source                  rsp
);

   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int SEC_SHIFT = $clog2(SECTOR_BYTES);
   localparam int ADDR_W    = scd_pkg::DISK_W + BLK_SHIFT;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

   scd_pkg::state_type state_ff, state_in;

   logic [scd_pkg::OP_W-1:0]   op_ff, op_in;
   logic [scd_pkg::TAG_W-1:0]  sector_ff, sector_in;
   logic [scd_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [IDX_W-1:0]           slot_ff, slot_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;
   logic                       free_found_ff, free_found_in;
   logic                       hit_ff, hit_in;
   logic                       pending_ff, pending_in;

   logic                       rsp_valid_ff;
   logic [scd_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [scd_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic [scd_pkg::TAG_W-1:0]  rsp_sector_ff;
   logic [scd_pkg::BYTE_W-1:0] rsp_byte_ff;
   logic                       rsp_hit_ff;
   logic                       rsp_flushed_ff;
   logic                       rsp_last_ff;

   logic                       out_load;
   logic [scd_pkg::KIND_W-1:0] out_kind;
   logic [scd_pkg::SLOT_W-1:0] out_slot;
   logic [scd_pkg::TAG_W-1:0]  out_sector;
   logic [scd_pkg::BYTE_W-1:0] out_byte;
   logic                       out_hit;
   logic                       out_flushed;
   logic                       out_last;

   logic                       out_free;
   logic                       accept;
   logic                       range_err;
   logic [ADDR_W-1:0]          addr;
   logic                       idx_last;
   logic                       wb_due;

   logic [IDX_W-1:0]           rd_idx;
   logic [IDX_W-1:0]           wr_idx;
   scd_pkg::dir_wr_type        wr_cmd;
   scd_pkg::dir_rd_type        rd;

   scd_dir #(.SLOTS(SLOTS)) u_dir (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .look_tag (sector_ff),
      .rd       (rd),
      .wr_cmd   (wr_cmd),
      .wr_idx   (wr_idx),
      .wr_tag   (sector_ff)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == scd_pkg::ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign range_err = req.block_number >= scd_pkg::BLK_W'(disk_blocks);
   assign addr      = (ADDR_W'(req.block_number[scd_pkg::DISK_W-1:0]) << BLK_SHIFT)
                      + ADDR_W'(req.block_offset);
   assign idx_last  = (idx_ff == IDX_LAST);
   assign wb_due    = rd.valid && rd.dirty;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scd_pkg::ST_IDLE: begin
            if (accept) begin
               case (req.operation)
                  scd_pkg::OP_READ, scd_pkg::OP_WRITE: begin
                     state_in = range_err ? scd_pkg::ST_IDLE : scd_pkg::ST_LOOKUP;
                  end
                  scd_pkg::OP_SERVICE: begin
                     state_in = pending_ff ? scd_pkg::ST_FLUSH : scd_pkg::ST_IDLE;
                  end
                  scd_pkg::OP_FLUSH_ALL: state_in = scd_pkg::ST_FLUSH;
                  default:               state_in = scd_pkg::ST_IDLE;
               endcase
            end
         end
         scd_pkg::ST_LOOKUP: begin
            if (rd.hit) begin
               state_in = scd_pkg::ST_GRANT;
            end else if (idx_last) begin
               state_in = (free_found_ff || !rd.valid) ? scd_pkg::ST_FILL
                                                       : scd_pkg::ST_VICTIM;
            end
         end
         scd_pkg::ST_VICTIM: begin
            if (!rd.dirty || out_free) begin
               state_in = scd_pkg::ST_FILL;
            end
         end
         scd_pkg::ST_FILL: begin
            if (out_free) begin
               state_in = scd_pkg::ST_GRANT;
            end
         end
         scd_pkg::ST_GRANT: begin
            if (out_free) begin
               state_in = scd_pkg::ST_IDLE;
            end
         end
         scd_pkg::ST_FLUSH: begin
            if ((!wb_due || out_free) && idx_last) begin
               state_in = scd_pkg::ST_DONE;
            end
         end
         scd_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = scd_pkg::ST_IDLE;
            end
         end
         default: state_in = scd_pkg::ST_IDLE;
      endcase
   end

   // Outputs: result load, directory read and write
   always_comb begin
      out_load    = 1'b0;
      out_kind    = scd_pkg::KIND_GRANT;
      out_slot    = '0;
      out_sector  = '0;
      out_byte    = '0;
      out_hit     = 1'b0;
      out_flushed = 1'b0;
      out_last    = 1'b0;
      wr_cmd      = '0;
      wr_idx      = slot_ff;
      rd_idx      = slot_ff;
      unique case (state_ff)
         scd_pkg::ST_IDLE: begin
            if (accept) begin
               case (req.operation)
                  scd_pkg::OP_READ, scd_pkg::OP_WRITE: begin
                     if (range_err) begin
                        out_load = 1'b1;
                        out_kind = scd_pkg::KIND_ERROR;
                        out_last = 1'b1;
                     end
                  end
                  scd_pkg::OP_START_STOP: begin
                     out_load = 1'b1;
                     out_kind = scd_pkg::KIND_DONE;
                     out_last = 1'b1;
                  end
                  scd_pkg::OP_SERVICE: begin
                     if (!pending_ff) begin
                        out_load = 1'b1;
                        out_kind = scd_pkg::KIND_DONE;
                        out_last = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         scd_pkg::ST_LOOKUP: rd_idx = idx_ff;
         scd_pkg::ST_VICTIM: begin
            rd_idx = '0;
            if (rd.dirty && out_free) begin
               out_load   = 1'b1;
               out_kind   = scd_pkg::KIND_WB;
               out_sector = rd.tag;
            end
         end
         scd_pkg::ST_FILL: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind    = scd_pkg::KIND_FILL;
               out_slot    = scd_pkg::SLOT_W'(slot_ff);
               out_sector  = sector_ff;
               wr_cmd.fill = 1'b1;
            end
         end
         scd_pkg::ST_GRANT: begin
            if (out_free) begin
               out_load         = 1'b1;
               out_kind         = scd_pkg::KIND_GRANT;
               out_slot         = scd_pkg::SLOT_W'(slot_ff);
               out_sector       = sector_ff;
               out_byte         = byte_ff;
               out_hit          = hit_ff;
               out_last         = 1'b1;
               wr_cmd.set_dirty = (op_ff == scd_pkg::OP_WRITE);
            end
         end
         scd_pkg::ST_FLUSH: begin
            rd_idx = idx_ff;
            wr_idx = idx_ff;
            if (wb_due && out_free) begin
               out_load         = 1'b1;
               out_kind         = scd_pkg::KIND_WB;
               out_slot         = scd_pkg::SLOT_W'(idx_ff);
               out_sector       = rd.tag;
               wr_cmd.clr_dirty = 1'b1;
            end
         end
         scd_pkg::ST_DONE: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind    = scd_pkg::KIND_DONE;
               out_flushed = 1'b1;
               out_last    = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Working registers
   always_comb begin
      op_in         = op_ff;
      sector_in     = sector_ff;
      byte_in       = byte_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      free_idx_in   = free_idx_ff;
      free_found_in = free_found_ff;
      hit_in        = hit_ff;
      pending_in    = pending_ff;
      case (state_ff)
         scd_pkg::ST_IDLE: begin
            if (accept) begin
               op_in         = req.operation;
               sector_in     = scd_pkg::TAG_W'(addr >> SEC_SHIFT);
               byte_in       = scd_pkg::BYTE_W'(addr[SEC_SHIFT-1:0]);
               idx_in        = '0;
               slot_in       = '0;
               free_found_in = 1'b0;
               hit_in        = 1'b0;
               if (req.operation == scd_pkg::OP_START_STOP && req.eject) begin
                  pending_in = 1'b1;
               end else if (req.operation == scd_pkg::OP_SERVICE) begin
                  pending_in = 1'b0;
               end
            end
         end
         scd_pkg::ST_LOOKUP: begin
            if (rd.hit) begin
               slot_in = idx_ff;
               hit_in  = 1'b1;
            end else begin
               if (!rd.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (idx_last) begin
                  // first invalid slot, else evict slot 0
                  if (free_found_ff) begin
                     slot_in = free_idx_ff;
                  end else if (!rd.valid) begin
                     slot_in = idx_ff;
                  end else begin
                     slot_in = '0;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         scd_pkg::ST_FLUSH: begin
            if ((!wb_due || out_free) && !idx_last) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scd_pkg::ST_IDLE;
         pending_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pending_ff    <= pending_in;
         free_found_ff <= free_found_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sector_ff   <= sector_in;
      byte_ff     <= byte_in;
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      free_idx_ff <= free_idx_in;
      hit_ff      <= hit_in;
      if (out_load) begin
         rsp_kind_ff    <= out_kind;
         rsp_slot_ff    <= out_slot;
         rsp_sector_ff  <= out_sector;
         rsp_byte_ff    <= out_byte;
         rsp_hit_ff     <= out_hit;
         rsp_flushed_ff <= out_flushed;
         rsp_last_ff    <= out_last;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_kind_ff;
   assign rsp.slot           = rsp_slot_ff;
   assign rsp.sector_number  = rsp_sector_ff;
   assign rsp.byte_in_sector = rsp_byte_ff;
   assign rsp.hit            = rsp_hit_ff;
   assign rsp.flushed        = rsp_flushed_ff;
   assign rsp.last           = rsp_last_ff;

   // A result that is not the final one of its item means the item is still at work
   a_mid_item_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> state_ff != scd_pkg::ST_IDLE)
      else $error("non-final result pending while idle");

   // Eviction only happens with every slot valid
   a_victim_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == scd_pkg::ST_VICTIM |-> rd.valid && !free_found_ff)
      else $error("eviction with a free slot");

   // The granted slot holds the sector
   a_grant_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == scd_pkg::ST_GRANT |-> rd.hit)
      else $error("grant slot does not hold the sector");

   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      accept && req.operation == scd_pkg::OP_FLUSH_ALL |=> state_ff == scd_pkg::ST_FLUSH
      && idx_ff == '0)
      else $error("flush all did not start a scan at slot 0");

endmodule

// ===== verif/tb.sv =====
module tb;

   localparam int CYCLE_LIMIT       = 400000;
   // settling wait after the last expected result, with margin
   localparam int DRAIN_CYCLES      = 24;
   localparam int BLOCKS_PER_SECTOR = scd_pkg::SECTOR_BYTES_DEF / scd_pkg::BLOCK_BYTES_DEF;
   localparam int POOL_SIZE         = 6;
   localparam int HOLD_AFTER        = 50;
   localparam int HOLD_CYCLES       = 200;

   // operation codes the block ignores
   localparam logic [scd_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [scd_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [scd_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [scd_pkg::KIND_W-1:0] kind;
      logic [scd_pkg::SLOT_W-1:0] slot;
      logic [scd_pkg::TAG_W-1:0]  sector_number;
      logic [scd_pkg::BYTE_W-1:0] byte_in_sector;
      logic                       hit;
      logic                       flushed;
      logic                       last;
   } sector_rsp_type;

   // typed rows carry the single result that is read off directly
   typedef struct packed {
      logic [scd_pkg::OP_W-1:0]   op;
      logic [scd_pkg::BLK_W-1:0]  blk;
      logic [scd_pkg::OFS_W-1:0]  ofs;
      logic                       eject;
      logic                       typed;
      logic [scd_pkg::KIND_W-1:0] exp_kind;
      logic                       exp_flushed;
   } stim_row_type;

   typedef struct packed {
      logic [scd_pkg::DISK_W-1:0] blocks;
      logic [15:0]                items;
   } phase_type;

   localparam int DIRECTED_ROWS = 22;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // cold miss fills slot 0, then a write hits it at the last byte of the block
      '{scd_pkg::OP_READ,  32'd0,     9'd0,   1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      '{scd_pkg::OP_WRITE, 32'd0,     9'd511, 1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      // last block of the disk, last byte of its sector
      '{scd_pkg::OP_READ,  32'd16383, 9'd511, 1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      // first block past the end, and the largest block number
      '{scd_pkg::OP_READ,  32'd16384, 9'd0,   1'b0, 1'b1, scd_pkg::KIND_ERROR, 1'b0},
      '{scd_pkg::OP_WRITE, 32'hFFFF_FFFF, 9'd511, 1'b1, 1'b1, scd_pkg::KIND_ERROR, 1'b0},
      '{scd_pkg::OP_WRITE, 32'd8,     9'd0,   1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      '{scd_pkg::OP_WRITE, 32'd16,    9'd256, 1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      // all slots valid: evict dirty slot 0, eject ignored on a read
      '{scd_pkg::OP_READ,  32'd24,    9'd0,   1'b1, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      '{scd_pkg::OP_START_STOP, 32'd0, 9'd0,  1'b0, 1'b1, scd_pkg::KIND_DONE,  1'b0},
      // service with nothing pending
      '{scd_pkg::OP_SERVICE, 32'd0,   9'd0,   1'b0, 1'b1, scd_pkg::KIND_DONE,  1'b0},
      '{scd_pkg::OP_START_STOP, 32'd0, 9'd0,  1'b1, 1'b1, scd_pkg::KIND_DONE,  1'b0},
      '{scd_pkg::OP_READ,  32'd8,     9'd1,   1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      // deferred flush carried out
      '{scd_pkg::OP_SERVICE, 32'd0,   9'd0,   1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      // nothing dirty left: done alone
      '{scd_pkg::OP_FLUSH_ALL, 32'd0, 9'd0,   1'b0, 1'b1, scd_pkg::KIND_DONE,  1'b1},
      '{OP_SPARE_5,        32'd0,     9'd0,   1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      '{OP_SPARE_6,        32'hFFFF_FFFF, 9'd511, 1'b1, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      '{OP_SPARE_7,        32'd8,     9'd0,   1'b1, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      '{scd_pkg::OP_WRITE, 32'd16383, 9'd0,   1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      // clean victim in slot 0, then a dirty one
      '{scd_pkg::OP_WRITE, 32'd1000,  9'd7,   1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      '{scd_pkg::OP_WRITE, 32'd0,     9'd0,   1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      '{scd_pkg::OP_FLUSH_ALL, 32'd0, 9'd0,   1'b0, 1'b0, scd_pkg::KIND_GRANT, 1'b0},
      '{scd_pkg::OP_SERVICE, 32'd0,   9'd0,   1'b0, 1'b1, scd_pkg::KIND_DONE,  1'b0}
   };

   logic clock;
   logic reset;

   scd_req_if req_bus ();
   scd_rsp_if rsp_bus ();
   scd_csr_if csr_bus ();

   write_back_sector_cache_directory_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // shadow of the directory and the block count
   logic [scd_pkg::TAG_W-1:0]  dir_tag   [scd_pkg::SLOTS_DEF];
   bit                         dir_valid [scd_pkg::SLOTS_DEF];
   bit                         dir_dirty [scd_pkg::SLOTS_DEF];
   bit                         flush_mark;
   logic [scd_pkg::DISK_W-1:0] disk_blocks_model;

   sector_rsp_type expected_rsp [$];
   int unsigned    hot_sectors [POOL_SIZE];
   int             mismatches;
   int             rsp_transfers;
   int             cycle_count;

   function automatic sector_rsp_type make_rsp(logic [scd_pkg::KIND_W-1:0] kind, int slot,
                                               logic [scd_pkg::TAG_W-1:0] sec,
                                               logic [scd_pkg::BYTE_W-1:0] pos,
                                               logic hit, logic flushed);
      sector_rsp_type r;
      r.kind           = kind;
      r.slot           = scd_pkg::SLOT_W'(slot);
      r.sector_number  = sec;
      r.byte_in_sector = pos;
      r.hit            = hit;
      r.flushed        = flushed;
      r.last           = 1'b0;
      return r;
   endfunction

   // write back every valid dirty slot in slot order and clean it
   function automatic void write_back_dirty(ref sector_rsp_type batch [$]);
      int i;
      for (i = 0; i < scd_pkg::SLOTS_DEF; i++) begin
         if (dir_valid[i] && dir_dirty[i]) begin
            batch.push_back(make_rsp(scd_pkg::KIND_WB, i, dir_tag[i], '0, 1'b0, 1'b0));
            dir_dirty[i] = 1'b0;
         end
      end
   endfunction

   // advance the shadow directory by one request and list the results it causes
   function automatic void predict_directory(input stim_row_type row,
                                             ref sector_rsp_type batch [$]);
      longint unsigned            byte_addr;
      logic [scd_pkg::TAG_W-1:0]  sec;
      logic [scd_pkg::BYTE_W-1:0] pos;
      int                         way;
      int                         i;
      logic                       hit;
      sector_rsp_type             r;
      batch = {};
      case (row.op)
         scd_pkg::OP_READ, scd_pkg::OP_WRITE: begin
            if (row.blk >= scd_pkg::BLK_W'(disk_blocks_model)) begin
               batch.push_back(make_rsp(scd_pkg::KIND_ERROR, 0, '0, '0, 1'b0, 1'b0));
            end else begin
               byte_addr = 64'(row.blk) * scd_pkg::BLOCK_BYTES_DEF + 64'(row.ofs);
               sec = scd_pkg::TAG_W'(byte_addr / scd_pkg::SECTOR_BYTES_DEF);
               pos = scd_pkg::BYTE_W'(byte_addr % scd_pkg::SECTOR_BYTES_DEF);
               way = -1;
               hit = 1'b0;
               for (i = 0; i < scd_pkg::SLOTS_DEF && way < 0; i++)
                  if (dir_valid[i] && dir_tag[i] == sec) way = i;
               if (way >= 0) begin
                  hit = 1'b1;
               end else begin
                  for (i = 0; i < scd_pkg::SLOTS_DEF && way < 0; i++)
                     if (!dir_valid[i]) way = i;
                  // full: slot 0 is always the victim
                  if (way < 0) begin
                     way = 0;
                     if (dir_dirty[0])
                        batch.push_back(make_rsp(scd_pkg::KIND_WB, 0, dir_tag[0], '0,
                                                 1'b0, 1'b0));
                  end
                  dir_tag[way]   = sec;
                  dir_valid[way] = 1'b1;
                  dir_dirty[way] = 1'b0;
                  batch.push_back(make_rsp(scd_pkg::KIND_FILL, way, sec, '0, 1'b0, 1'b0));
               end
               batch.push_back(make_rsp(scd_pkg::KIND_GRANT, way, sec, pos, hit, 1'b0));
               if (row.op == scd_pkg::OP_WRITE) dir_dirty[way] = 1'b1;
            end
         end
         scd_pkg::OP_START_STOP: begin
            if (row.eject) flush_mark = 1'b1;
            batch.push_back(make_rsp(scd_pkg::KIND_DONE, 0, '0, '0, 1'b0, 1'b0));
         end
         scd_pkg::OP_SERVICE: begin
            if (flush_mark) begin
               flush_mark = 1'b0;
               write_back_dirty(batch);
               batch.push_back(make_rsp(scd_pkg::KIND_DONE, 0, '0, '0, 1'b0, 1'b1));
            end else begin
               batch.push_back(make_rsp(scd_pkg::KIND_DONE, 0, '0, '0, 1'b0, 1'b0));
            end
         end
         scd_pkg::OP_FLUSH_ALL: begin
            write_back_dirty(batch);
            batch.push_back(make_rsp(scd_pkg::KIND_DONE, 0, '0, '0, 1'b0, 1'b1));
         end
         default: ;
      endcase
      if (batch.size() > 0) begin
         r = batch.pop_back();
         r.last = 1'b1;
         batch.push_back(r);
      end
   endfunction

   // random request: mostly accesses to a small set of hot sectors so that
   // hits, fills and evictions all happen; the rest is control and noise
   function automatic stim_row_type random_request();
      stim_row_type row;
      int           pick;
      int unsigned  blk;
      row       = '0;
      row.ofs   = scd_pkg::OFS_W'($urandom);
      row.eject = 1'($urandom_range(0, 1));
      pick      = $urandom_range(0, 99);
      if (pick < 70) begin
         row.op = $urandom_range(0, 1) ? scd_pkg::OP_WRITE : scd_pkg::OP_READ;
         if (pick < 60 && disk_blocks_model != 0) begin
            blk = hot_sectors[$urandom_range(0, POOL_SIZE - 1)] * BLOCKS_PER_SECTOR
                  + $urandom_range(0, BLOCKS_PER_SECTOR - 1);
            if (blk >= disk_blocks_model) blk = disk_blocks_model - 1;
            row.blk = scd_pkg::BLK_W'(blk);
         end else if (pick < 64) begin
            row.blk = scd_pkg::BLK_W'(disk_blocks_model);
         end else if (pick < 66) begin
            row.blk = scd_pkg::BLK_W'(disk_blocks_model) - 1;
         end else begin
            row.blk = $urandom;
         end
      end else if (pick < 78) begin
         row.op = scd_pkg::OP_START_STOP;
      end else if (pick < 88) begin
         row.op = scd_pkg::OP_SERVICE;
      end else if (pick < 95) begin
         row.op = scd_pkg::OP_FLUSH_ALL;
      end else begin
         case ($urandom_range(0, 2))
            0:       row.op = OP_SPARE_5;
            1:       row.op = OP_SPARE_6;
            default: row.op = OP_SPARE_7;
         endcase
         row.blk = $urandom;
      end
      return row;
   endfunction

   // request gap: mostly none or short, now and then long, with bursts of none
   int burst_left;
   function automatic int request_gap();
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) burst_left = $urandom_range(10, 25);
      if (pick < 60) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // offer one request; valid stays high after the transfer until the next call
   task automatic send_request(input stim_row_type row);
      int             gap;
      sector_rsp_type batch [$];
      sector_rsp_type typed_rsp;
      gap = request_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= row.op;
      req_bus.block_number <= row.blk;
      req_bus.block_offset <= row.ofs;
      req_bus.eject        <= row.eject;
      do @(posedge clock); while (!req_bus.ready);
      predict_directory(row, batch);
      if (row.typed) begin
         typed_rsp      = make_rsp(row.exp_kind, 0, '0, '0, 1'b0, row.exp_flushed);
         typed_rsp.last = 1'b1;
         expected_rsp.push_back(typed_rsp);
      end else begin
         foreach (batch[i]) expected_rsp.push_back(batch[i]);
      end
   endtask

   // drop valid and wait until every expected result is back
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write the block count only while the block is idle
   task automatic write_disk_blocks(input logic [scd_pkg::DISK_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      disk_blocks_model = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop on a hang
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: random stalls, one long hold-off, check every transfer
   initial begin : rsp_side
      int             hold_left;
      int             stall_left;
      int             free_left;
      int             pick;
      bit             hold_done;
      sector_rsp_type got;
      sector_rsp_type want;
      hold_left     = 0;
      stall_left    = 0;
      free_left     = 0;
      hold_done     = 1'b0;
      rsp_transfers = 0;
      mismatches    = 0;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         // hold off long enough that the block fills up and stalls its input
         if (!hold_done && rsp_transfers >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (free_left > 0) begin
               free_left--;
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 8)
                  free_left = $urandom_range(10, 40);
               else if (pick < 33)
                  stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                           : $urandom_range(1, 3);
            end
         end
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
            rsp_transfers++;
            got.kind           = rsp_bus.kind;
            got.slot           = rsp_bus.slot;
            got.sector_number  = rsp_bus.sector_number;
            got.byte_in_sector = rsp_bus.byte_in_sector;
            got.hit            = rsp_bus.hit;
            got.flushed        = rsp_bus.flushed;
            got.last           = rsp_bus.last;
            if (expected_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual %p", $time, got);
            end else begin
               want = expected_rsp.pop_front();
               check_field("kind", 32'(want.kind), 32'(got.kind));
               check_field("slot", 32'(want.slot), 32'(got.slot));
               check_field("sector_number", 32'(want.sector_number),
                           32'(got.sector_number));
               check_field("byte_in_sector", 32'(want.byte_in_sector),
                           32'(got.byte_in_sector));
               check_field("hit", 32'(want.hit), 32'(got.hit));
               check_field("flushed", 32'(want.flushed), 32'(got.flushed));
               check_field("last", 32'(want.last), 32'(got.last));
            end
         end
      end
   end

   // request side: directed table, then random phases at several block counts
   initial begin : req_side
      phase_type    phases [6];
      stim_row_type row;
      int           sent;
      int unsigned  max_sector;
      int           k;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.operation    = scd_pkg::OP_READ;
      req_bus.block_number = '0;
      req_bus.block_offset = '0;
      req_bus.eject        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.data         = '0;
      burst_left           = 0;

      // shadow state after reset
      for (k = 0; k < scd_pkg::SLOTS_DEF; k++) begin
         dir_tag[k]   = '1;
         dir_valid[k] = 1'b0;
         dir_dirty[k] = 1'b0;
      end
      flush_mark        = 1'b0;
      disk_blocks_model = scd_pkg::DISK_BLOCKS_RST;

      // first phase runs on the reset count; zero and all ones cover every bit
      phases[0] = '{scd_pkg::DISK_BLOCKS_RST, 16'd30};
      phases[1] = '{16'd0,           16'd8};
      phases[2] = '{16'hFFFF,        16'd30};
      phases[3] = '{16'd1,           16'd12};
      phases[4] = '{16'd32768,       16'd32};
      phases[5] = '{scd_pkg::DISK_W'($urandom_range(2, 600)), 16'd30};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIRECTED_ROWS; k++) send_request(DIRECTED[k]);

      foreach (phases[p]) begin
         // the write drains all outstanding results first
         if (p > 0) write_disk_blocks(phases[p].blocks);

         // hot sectors within range; above 4096 sectors, force a tag alias
         max_sector = (disk_blocks_model == 0) ? 0
                      : (int'(disk_blocks_model) - 1) / BLOCKS_PER_SECTOR;
         for (k = 0; k < POOL_SIZE; k++) hot_sectors[k] = $urandom_range(0, max_sector);
         if (max_sector >= (1 << scd_pkg::TAG_W))
            hot_sectors[1] = hot_sectors[0] ^ (1 << scd_pkg::TAG_W);

         sent = 0;
         while (sent < phases[p].items) begin
            row = random_request();
            send_request(row);
            if (row.op <= scd_pkg::OP_FLUSH_ALL) sent++;
         end
      end

      drain_results();

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
